@@ rtl/core/cgapv_pkg.sv @@
`default_nettype none

package cgapv_pkg;

    // Default vector length.
    localparam int GENES_DEFAULT = 32;

    // Probability format and bounds in Q0.16.
    localparam int          PROB_W    = 16;
    localparam logic [15:0] PROB_MIN  = 16'd1;
    localparam logic [15:0] PROB_MAX  = 16'd65535;
    localparam logic [15:0] PROB_HALF = 16'd32768;

    // Random generator.
    localparam logic [31:0] LFSR_MASK  = 32'h8020_0003;
    localparam logic [31:0] LFSR_RESET = 32'd1;

    // Command mode codes.
    localparam logic [1:0] MODE_UPDATE  = 2'd0;
    localparam logic [1:0] MODE_SAMPLE  = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    // Configuration register indexes and reset values.
    localparam logic        REG_STEP   = 1'b0;
    localparam logic        REG_SEED   = 1'b1;
    localparam logic [15:0] STEP_RESET = 16'd655;

    // Command transaction.
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] winner_bits;
        logic [31:0] loser_bits;
    } cmd_t;

    // Result transaction.
    typedef struct packed {
        logic [31:0] sample_bits;
        logic        converged;
    } result_t;

    // Operands handed to the gene unit for the gene at the head of the chain.
    typedef struct packed {
        logic [1:0]  mode;
        logic        win;
        logic        lose;
        logic [15:0] step;
        logic [31:0] lfsr;
    } gene_ctl_t;

    // What the gene unit returns for that gene.
    typedef struct packed {
        logic [15:0] prob;
        logic [31:0] lfsr;
        logic        sample_bit;
        logic        at_bound;
    } gene_res_t;

endpackage

`default_nettype wire

@@ rtl/core/cgapv_cell.sv @@
`default_nettype none

// One probability entry of the ring. When the ring rotates it takes the
// value of its neighbor further down the chain.
module cgapv_cell (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        shift,
    input  wire logic [15:0] d,
    output logic      [15:0] q
);

    logic [15:0] prob_reg;

    // Entry register, reset to one half.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prob_reg <= cgapv_pkg::PROB_HALF;
        end
        else if (shift)
        begin
            prob_reg <= d;
        end
    end

    assign q = prob_reg;

endmodule

`default_nettype wire

@@ rtl/core/cgapv_gene_unit.sv @@
`default_nettype none

// Processes the gene at the head of the chain: update, sample draw or
// restart, and reports whether the new value sits on a bound.
module cgapv_gene_unit (
    input  wire logic                 [15:0] prob,
    input  wire cgapv_pkg::gene_ctl_t        ctl,
    output cgapv_pkg::gene_res_t             res
);

    logic [16:0] sum;
    logic [15:0] up_val;
    logic [15:0] down_val;
    logic [15:0] upd_val;
    logic [31:0] lfsr_step;

    // Saturating step up and down.
    always_comb
    begin
        sum      = {1'b0, prob} + {1'b0, ctl.step};
        up_val   = sum[16] ? cgapv_pkg::PROB_MAX : sum[15:0];
        down_val = (prob <= ctl.step) ? cgapv_pkg::PROB_MIN : (prob - ctl.step);
        if (ctl.win && !ctl.lose)
        begin
            upd_val = up_val;
        end
        else if (!ctl.win && ctl.lose)
        begin
            upd_val = down_val;
        end
        else
        begin
            upd_val = prob;
        end
    end

    // One Galois step of the random generator.
    assign lfsr_step = (ctl.lfsr >> 1) ^ (ctl.lfsr[0] ? cgapv_pkg::LFSR_MASK : 32'd0);

    // Mode decode.
    always_comb
    begin
        res.prob       = prob;
        res.lfsr       = ctl.lfsr;
        res.sample_bit = 1'b0;
        unique case (ctl.mode)
            cgapv_pkg::MODE_UPDATE:
            begin
                res.prob = upd_val;
            end
            cgapv_pkg::MODE_SAMPLE:
            begin
                res.lfsr       = lfsr_step;
                res.sample_bit = prob > lfsr_step[15:0];
            end
            cgapv_pkg::MODE_RESTART:
            begin
                res.prob = cgapv_pkg::PROB_HALF;
            end
            default:
            begin
                res.prob = prob;
            end
        endcase
        res.at_bound = (res.prob == cgapv_pkg::PROB_MIN) ||
                       (res.prob == cgapv_pkg::PROB_MAX);
    end

endmodule

`default_nettype wire

@@ rtl/core/compact_ga_probability_vector.sv @@
`default_nettype none

// Compact genetic algorithm probability vector.
// The GENES probabilities (Q0.16, reset to one half) live in a ring of cells.
// A command transaction is accepted at a clock edge with start high and busy
// low; cmd.mode selects update (move each gene whose winner and loser bits
// differ by the step register, saturating to [1, 65535]), sample (draw one
// 16-bit number per gene from a 32-bit Galois LFSR) or restart (all to one
// half). While busy the ring rotates once per cycle and the gene at its head
// passes through the single gene unit, one gene after another.
// The result transaction is shown on result for one cycle with done high,
// once the last gene has left the gene unit; a new command may be accepted in
// that same cycle, but never while a pass is still running.
// The receiver cannot stall; it must take the result when done is high.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; a
// seed write reloads the LFSR (zero loads one) but is lost during a pass.
// Reset sets every probability to one half, the step to 655 and the LFSR to 1.
module compact_ga_probability_vector #(
    parameter int GENES = cgapv_pkg::GENES_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire cgapv_pkg::cmd_t    cmd,
    output logic                    done,
    output cgapv_pkg::result_t      result,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [31:0]        cfg_data
);

    localparam int CNT_W = (GENES > 1) ? $clog2(GENES) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(GENES - 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [1:0]            mode_reg;
    logic [31:0]           win_reg;
    logic [31:0]           lose_reg;
    logic [31:0]           mask_reg;
    logic [31:0]           sample_reg;
    logic                  conv_reg;
    logic [15:0]           step_reg;
    logic [31:0]           lfsr_reg;
    logic                  done_reg;
    cgapv_pkg::result_t    result_reg;

    logic [15:0]           prob [GENES];
    logic                  shift;
    cgapv_pkg::gene_ctl_t  ctl;
    cgapv_pkg::gene_res_t  res;

    assign shift = (state_reg == ST_RUN);

    // Ring of cells: each takes its upper neighbor, the last takes the
    // processed head value.
    for (genvar k = 0; k < GENES; k++)
    begin : g_cell
        logic [15:0] d;
        if (k == GENES - 1)
        begin : g_tail
            assign d = res.prob;
        end
        else
        begin : g_mid
            assign d = prob[k+1];
        end
        cgapv_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .d     (d),
            .q     (prob[k])
        );
    end

    // Operands for the head gene.
    always_comb
    begin
        ctl.mode = mode_reg;
        ctl.win  = win_reg[0];
        ctl.lose = lose_reg[0];
        ctl.step = step_reg;
        ctl.lfsr = lfsr_reg;
    end

    cgapv_gene_unit u_gene (
        .prob (prob[0]),
        .ctl  (ctl),
        .res  (res)
    );

    // Sequencer, configuration registers and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            mode_reg   <= cgapv_pkg::MODE_UPDATE;
            win_reg    <= '0;
            lose_reg   <= '0;
            mask_reg   <= '0;
            sample_reg <= '0;
            conv_reg   <= 1'b0;
            step_reg   <= cgapv_pkg::STEP_RESET;
            lfsr_reg   <= cgapv_pkg::LFSR_RESET;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            // The strobe follows the last gene of a pass.
            done_reg <= (state_reg == ST_RUN) && (cnt_reg == LAST);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    cgapv_pkg::REG_STEP:
                    begin
                        step_reg <= cfg_data[15:0];
                    end
                    cgapv_pkg::REG_SEED:
                    begin
                        lfsr_reg <= (cfg_data == 32'd0) ? cgapv_pkg::LFSR_RESET : cfg_data;
                    end
                    default:
                    begin
                        step_reg <= step_reg;
                    end
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg  <= ST_RUN;
                        cnt_reg    <= '0;
                        mode_reg   <= cmd.mode;
                        win_reg    <= cmd.winner_bits;
                        lose_reg   <= cmd.loser_bits;
                        mask_reg   <= 32'd1;
                        sample_reg <= '0;
                        conv_reg   <= 1'b1;
                    end
                end
                ST_RUN:
                begin
                    lfsr_reg   <= res.lfsr;
                    win_reg    <= win_reg >> 1;
                    lose_reg   <= lose_reg >> 1;
                    mask_reg   <= mask_reg << 1;
                    sample_reg <= sample_reg | (mask_reg & {32{res.sample_bit}});
                    conv_reg   <= conv_reg & res.at_bound;
                    cnt_reg    <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST)
                    begin
                        state_reg              <= ST_IDLE;
                        result_reg.sample_bits <= sample_reg |
                                                  (mask_reg & {32{res.sample_bit}});
                        result_reg.converged   <= conv_reg & res.at_bound;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg == ST_RUN);
    assign done   = done_reg;
    assign result = result_reg;

    // A result never appears while a command is still in progress.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // An accepted command always starts a pass.
    assert property (@(posedge clk) disable iff (!rst_n) start && !busy |=> busy)
        else $error("accepted command did not start");

    // Only a sample command reports drawn bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && (mode_reg != cgapv_pkg::MODE_SAMPLE) |-> result.sample_bits == 32'd0)
        else $error("sample bits outside sample mode");

    // After a restart every entry is one half, so the vector is not converged.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && (mode_reg == cgapv_pkg::MODE_RESTART) |-> !result.converged)
        else $error("converged reported after restart");

endmodule

`default_nettype wire

@@ bench/cgapv_vector_checker.sv @@
`timescale 1ns / 1ps

// Watches the command, result and register channels of the probability vector.
// It keeps its own copy of the probabilities, the LFSR and the step, predicts
// the result of every accepted command and compares it with what the block
// reports.
module cgapv_vector_checker #(
    parameter int GENES = cgapv_pkg::GENES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  cgapv_pkg::cmd_t     cmd,
    input  logic                done,
    input  cgapv_pkg::result_t  result,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data,
    output int                  mismatches,
    output int                  outstanding,
    output int                  results_seen,
    output int                  converged_seen
);
    import cgapv_pkg::*;

    logic [15:0] prob_vec [GENES];
    logic [31:0] lfsr_q;
    logic [15:0] step_q;
    result_t     vector_results_q [$];

    task automatic note_mismatch(input string field, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
        end
    endtask

    // Apply one command to the vector copy and work out the result it yields.
    task automatic run_command(input cmd_t c, output result_t r);
        int   level;
        logic win_b;
        logic lose_b;
        logic all_at_bound;
        r = '0;
        case (c.mode)
            MODE_UPDATE:
            begin
                for (int i = 0; i < GENES; i++)
                begin
                    // Genes past bit 31 see zero on both sides and never move.
                    win_b  = (i < 32) ? c.winner_bits[i % 32] : 1'b0;
                    lose_b = (i < 32) ? c.loser_bits[i % 32] : 1'b0;
                    level  = int'(prob_vec[i]);
                    if (win_b != lose_b)
                    begin
                        level = win_b ? level + int'(step_q) : level - int'(step_q);
                    end
                    if (level < int'(PROB_MIN))
                    begin
                        level = int'(PROB_MIN);
                    end
                    if (level > int'(PROB_MAX))
                    begin
                        level = int'(PROB_MAX);
                    end
                    prob_vec[i] = level[15:0];
                end
            end
            MODE_SAMPLE:
            begin
                // The LFSR steps once per gene before its draw is taken.
                for (int i = 0; i < GENES; i++)
                begin
                    lfsr_q = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_MASK) : (lfsr_q >> 1);
                    if (i < 32 && prob_vec[i] > lfsr_q[15:0])
                    begin
                        r.sample_bits[i % 32] = 1'b1;
                    end
                end
            end
            MODE_RESTART:
            begin
                foreach (prob_vec[i])
                begin
                    prob_vec[i] = PROB_HALF;
                end
            end
            default:
            begin
                // The unused mode leaves everything as it is.
            end
        endcase

        all_at_bound = 1'b1;
        foreach (prob_vec[i])
        begin
            if (prob_vec[i] > PROB_MIN && prob_vec[i] < PROB_MAX)
            begin
                all_at_bound = 1'b0;
            end
        end
        r.converged = all_at_bound;
    endtask

    // Register writes, result comparison and command prediction, in that order,
    // so that a result leaving in the same cycle as a new command is matched
    // against the older expectation.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            foreach (prob_vec[i])
            begin
                prob_vec[i] = PROB_HALF;
            end
            lfsr_q = LFSR_RESET;
            step_q = STEP_RESET;
            vector_results_q.delete();
            mismatches     = 0;
            outstanding    = 0;
            results_seen   = 0;
            converged_seen = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_STEP)
                begin
                    step_q = cfg_data[15:0];
                end
                else
                begin
                    // A zero seed would lock the LFSR, so one is loaded instead.
                    lfsr_q = (cfg_data == 32'd0) ? LFSR_RESET : cfg_data;
                end
            end

            if (done)
            begin
                results_seen++;
                if (result.converged === 1'b1)
                begin
                    converged_seen++;
                end
                if (vector_results_q.size() == 0)
                begin
                    note_mismatch("unexpected result transaction", 32'd0, result.sample_bits);
                end
                else
                begin
                    want = vector_results_q.pop_front();
                    if (result.sample_bits !== want.sample_bits)
                    begin
                        note_mismatch("sample_bits", want.sample_bits, result.sample_bits);
                    end
                    if (result.converged !== want.converged)
                    begin
                        note_mismatch("converged", 32'(want.converged), 32'(result.converged));
                    end
                end
            end

            if (start && !busy)
            begin
                run_command(cmd, want);
                vector_results_q.push_back(want);
            end
            outstanding = vector_results_q.size();
        end
    end

endmodule

@@ bench/tb_compact_ga_probability_vector.sv @@
`timescale 1ns / 1ps

module tb_compact_ga_probability_vector;
    import cgapv_pkg::*;

    localparam int         GENES       = GENES_DEFAULT;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         STALL_LIMIT = 2000;
    localparam int         PHASES      = 6;
    localparam int         PHASE_ITEMS = 250;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        done;
    result_t     result;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    int          mismatches;
    int          outstanding;
    int          results_seen;
    int          converged_seen;
    int          mode_count [4];
    int          reg_writes  = 0;
    int          quiet_cycles = 0;
    int          burst_left  = 0;
    logic [31:0] target_genome;
    logic [15:0] phase_step;

    compact_ga_probability_vector #(
        .GENES(GENES)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    cgapv_vector_checker #(
        .GENES(GENES)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .done          (done),
        .result        (result),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .converged_seen(converged_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic cmd_t make_cmd(input logic [1:0] m, input logic [31:0] w,
                                      input logic [31:0] l);
        cmd_t c;
        c.mode        = m;
        c.winner_bits = w;
        c.loser_bits  = l;
        return c;
    endfunction

    // Mostly a GA run toward one genome: winners close to it, losers near its
    // complement or random, interleaved with samples; the rest is noise.
    function automatic cmd_t ga_command(input logic [31:0] goal);
        int          roll;
        logic [31:0] noise;
        logic [31:0] win;
        roll  = $urandom_range(0, 99);
        noise = $urandom & $urandom & $urandom;
        win   = goal ^ noise;
        if (roll < 25)
        begin
            return make_cmd(MODE_UPDATE, win, ~goal ^ ($urandom & $urandom & $urandom));
        end
        else if (roll < 45)
        begin
            return make_cmd(MODE_UPDATE, win, $urandom);
        end
        else if (roll < 80)
        begin
            return make_cmd(MODE_SAMPLE, $urandom, $urandom);
        end
        else if (roll < 85)
        begin
            return make_cmd(MODE_RESTART, $urandom, $urandom);
        end
        else if (roll < 90)
        begin
            return make_cmd(MODE_UNUSED, $urandom, $urandom);
        end
        return make_cmd(MODE_UPDATE, $urandom, $urandom);
    endfunction

    // Present one command from a falling edge and hold it until it is taken.
    // Start stays high afterwards so that back-to-back commands need no gap.
    task automatic issue(input cmd_t c);
        start = 1'b1;
        cmd   = c;
        do
            @(posedge clk);
        while (busy);
        mode_count[c.mode]++;
        @(negedge clk);
    endtask

    task automatic pause(input int cycles);
        start = 1'b0;
        cmd   = make_cmd(2'($urandom), $urandom, $urandom);
        repeat (cycles) @(negedge clk);
    endtask

    // Stop sending until every expected result has come back.
    task automatic drain();
        start = 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        reg_writes++;
    endtask

    // Sender pacing: bursts of random length separated by random gaps, with
    // an occasional long burst that keeps the block fully loaded.
    task automatic pace();
        if (burst_left == 0)
        begin
            pause(($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8));
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 25);
        end
        else
        begin
            burst_left--;
        end
    endtask

    initial
    begin
        foreach (mode_count[i])
        begin
            mode_count[i] = 0;
        end
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_STEP;
        cfg_data  = 32'd0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at reset settings: moves both ways, equal bits, the
        // unused mode, restart and samples in between.
        issue(make_cmd(MODE_SAMPLE, 32'h0, 32'h0));
        issue(make_cmd(MODE_UPDATE, 32'hFFFF_FFFF, 32'h0));
        issue(make_cmd(MODE_UPDATE, 32'h0, 32'hFFFF_FFFF));
        issue(make_cmd(MODE_UPDATE, 32'hA5A5_A5A5, 32'hA5A5_A5A5));
        issue(make_cmd(MODE_UPDATE, 32'hAAAA_AAAA, 32'h5555_5555));
        issue(make_cmd(MODE_UNUSED, $urandom, $urandom));
        issue(make_cmd(MODE_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        issue(make_cmd(MODE_RESTART, 32'h0, 32'h0));
        issue(make_cmd(MODE_SAMPLE, 32'h0, 32'h0));

        // Largest regular step with a zero seed: saturate at the top, then at
        // the bottom, so the vector converges both ways.
        drain();
        write_reg(REG_STEP, 32'd32768);
        write_reg(REG_SEED, 32'd0);
        issue(make_cmd(MODE_UPDATE, 32'hFFFF_FFFF, 32'h0));
        issue(make_cmd(MODE_UPDATE, 32'hFFFF_FFFF, 32'h0));
        issue(make_cmd(MODE_SAMPLE, 32'h0, 32'h0));
        issue(make_cmd(MODE_UPDATE, 32'h0, 32'hFFFF_FFFF));
        issue(make_cmd(MODE_UPDATE, 32'h0, 32'hFFFF_FFFF));
        issue(make_cmd(MODE_UPDATE, 32'h0, 32'hFFFF_FFFF));
        issue(make_cmd(MODE_SAMPLE, 32'h0, 32'h0));
        issue(make_cmd(MODE_UPDATE, 32'hFFFF_0000, 32'h0000_FFFF));
        issue(make_cmd(MODE_RESTART, 32'h0, 32'h0));

        // A zero step must leave the vector alone; all-ones seed.
        drain();
        write_reg(REG_STEP, 32'd0);
        write_reg(REG_SEED, 32'hFFFF_FFFF);
        issue(make_cmd(MODE_UPDATE, 32'hFFFF_FFFF, 32'h0));
        issue(make_cmd(MODE_SAMPLE, 32'h0, 32'h0));

        // Smallest nonzero step, then the widest one the register holds.
        drain();
        write_reg(REG_STEP, 32'd1);
        write_reg(REG_SEED, 32'h8000_0000);
        issue(make_cmd(MODE_UPDATE, 32'h0, 32'hFFFF_FFFF));
        issue(make_cmd(MODE_SAMPLE, 32'h0, 32'h0));
        drain();
        write_reg(REG_STEP, 32'h0000_FFFF);
        issue(make_cmd(MODE_UPDATE, 32'h5555_5555, 32'hAAAA_AAAA));
        issue(make_cmd(MODE_SAMPLE, 32'h0, 32'h0));

        // Random part: one GA run per phase, each with its own step and seed.
        for (int k = 0; k < PHASES; k++)
        begin
            drain();
            case (k)
                0: phase_step = 16'd1;
                1: phase_step = STEP_RESET;
                2: phase_step = 16'($urandom_range(1, 4096));
                3: phase_step = 16'd8192;
                4: phase_step = 16'd32768;
                default: phase_step = 16'($urandom_range(0, 65535));
            endcase
            write_reg(REG_STEP, {16'h0, phase_step});
            write_reg(REG_SEED, (k == 2) ? 32'd0 : $urandom);
            target_genome = $urandom;
            if (k % 2 == 1)
            begin
                issue(make_cmd(MODE_RESTART, $urandom, $urandom));
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 79) == 0)
                begin
                    target_genome = $urandom;
                end
                issue(ga_command(target_genome));
                if ($urandom_range(0, 49) == 0)
                begin
                    drain();
                end
                pace();
            end
        end

        drain();
        repeat (GENES + 8) @(negedge clk);
        $display("Sent %0d commands: %0d update, %0d sample, %0d restart, %0d unused; %0d writes.",
                 mode_count[MODE_UPDATE] + mode_count[MODE_SAMPLE] + mode_count[MODE_RESTART]
                 + mode_count[MODE_UNUSED], mode_count[MODE_UPDATE], mode_count[MODE_SAMPLE],
                 mode_count[MODE_RESTART], mode_count[MODE_UNUSED], reg_writes);
        $display("Checked %0d results, %0d of them with a converged vector; %0d mismatches.",
                 results_seen, converged_seen, mismatches);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
